// ===== rtl/core/diploid_nucleotide_distance_unit_defines.svh =====
// Assertion helpers for the nucleotide distance unit.
// Each macro expects clk and arst_n in scope.
`ifndef DIPLOID_NUCLEOTIDE_DISTANCE_UNIT_DEFINES_SVH
`define DIPLOID_NUCLEOTIDE_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DND_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dnd: same-cycle property violated");

// Next-cycle implication.
`define DND_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dnd: next-cycle property violated");

`endif

// ===== rtl/core/dnd_pkg.sv =====
`default_nettype none
package dnd_pkg;

	localparam int unsigned MAX_BLOCKS    = 64;
	localparam int unsigned WORD_W        = 64;
	localparam int unsigned NUCS_PER_WORD = WORD_W / 2;
	localparam int unsigned SUM_W         = 12;
	localparam int unsigned CNT_W         = $clog2(NUCS_PER_WORD + 1);
	localparam int unsigned NUM_PAIRS     = 4;
	localparam int unsigned SUM_CAP_RAW   = NUCS_PER_WORD * MAX_BLOCKS;
	localparam int unsigned SUM_CAP       =
		(SUM_CAP_RAW > (2 ** SUM_W - 1)) ? (2 ** SUM_W - 1) : SUM_CAP_RAW;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Chromosome pairings: genome one side first, genome two side second.
	typedef enum logic [1:0] {
		PAIR_FF,
		PAIR_SS,
		PAIR_SF,
		PAIR_FS
	} pair_t;

	localparam sum_t  SUM_MAX   = sum_t'(SUM_CAP);
	localparam word_t PAIR_LSB  = 64'h5555_5555_5555_5555;
	localparam word_t NIB_MASK  = 64'h3333_3333_3333_3333;
	localparam word_t BYTE_MASK = 64'h0f0f_0f0f_0f0f_0f0f;

	// Count nonzero two-bit groups of w.
	function automatic cnt_t diff_nucs(input word_t w);
		word_t v;
		cnt_t  acc;
		v   = (w & PAIR_LSB) | ((w >> 1) & PAIR_LSB);
		v   = (v & NIB_MASK) + ((v >> 2) & NIB_MASK);
		v   = (v + (v >> 4)) & BYTE_MASK;
		acc = '0;
		for (int i = 0; i < WORD_W / 8; i++) begin
			acc = acc + cnt_t'(v[i*8 +: 8]);
		end
		return acc;
	endfunction

	// Add and clamp at SUM_MAX.
	function automatic sum_t sat_add(input sum_t acc, input cnt_t add);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + (SUM_W + 1)'(add);
		return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dnd_blk_if.sv =====
`default_nettype none
interface dnd_blk_if;
	logic                       valid;
	logic                       ready;
	logic [dnd_pkg::WORD_W-1:0] g1_first_word;
	logic [dnd_pkg::WORD_W-1:0] g1_second_word;
	logic [dnd_pkg::WORD_W-1:0] g2_first_word;
	logic [dnd_pkg::WORD_W-1:0] g2_second_word;
	logic                       last_block;

	modport source (
		output valid, g1_first_word, g1_second_word, g2_first_word, g2_second_word,
			last_block,
		input  ready
	);
	modport sink (
		input  valid, g1_first_word, g1_second_word, g2_first_word, g2_second_word,
			last_block,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/dnd_res_if.sv =====
`default_nettype none
interface dnd_res_if;
	logic                      valid;
	logic                      ready;
	logic [dnd_pkg::SUM_W-1:0] min_distance;

	modport source (output valid, min_distance, input ready);
	modport sink   (input valid, min_distance, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/diploid_nucleotide_distance_unit.sv =====
// A block marked last passes through stage 1, stage 2, stage 3 and the output register before its result shows.
// Throughput: one block per cycle while blk.ready is high; the four pairing accumulators take one add per cycle.
// A waiting result does not stop non-final blocks; a final block waits while stage 3 cannot move on.
// Reset (arst_n low, asynchronous) empties all stages and clears the four sums.
`default_nettype none
`include "diploid_nucleotide_distance_unit_defines.svh"
module diploid_nucleotide_distance_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	dnd_blk_if.sink   blk,
	dnd_res_if.source res
);
	import dnd_pkg::*;

	// Stage 1: registered input block.
	logic  v_s1;
	word_t a1_s1, a2_s1, b1_s1, b2_s1;
	logic  last_s1;

	// Stage 2: per-pairing difference counts.
	logic  v_s2;
	cnt_t  cnt_s2 [NUM_PAIRS];
	logic  last_s2;

	// Running sums, one per pairing.
	sum_t  acc_q [NUM_PAIRS];
	sum_t  sum_next [NUM_PAIRS];

	// Stage 3: final sums of a finished genome.
	logic  v_s3;
	sum_t  sum_s3 [NUM_PAIRS];
	sum_t  min_a, min_b, min_s3;

	// Output register.
	logic  out_v_q;
	sum_t  min_q;

	// Flow control: each stage frees when its content moves on.
	logic out_free, s3_free, s2_take, s2_free, s1_free;

	assign out_free = !out_v_q || res.ready;
	assign s3_free  = !v_s3 || out_free;
	// A non-final block only updates the sums; a final one also needs stage 3.
	assign s2_take  = v_s2 && (!last_s2 || s3_free);
	assign s2_free  = !v_s2 || s2_take;
	assign s1_free  = !v_s1 || s2_free;

	assign blk.ready = s1_free;

	always_comb begin
		for (int p = 0; p < NUM_PAIRS; p++) begin
			sum_next[p] = sat_add(acc_q[p], cnt_s2[p]);
		end
	end

	// Smallest of the four final sums, as a two-level compare tree.
	always_comb begin
		min_a  = (sum_s3[PAIR_SS] < sum_s3[PAIR_FF]) ? sum_s3[PAIR_SS] : sum_s3[PAIR_FF];
		min_b  = (sum_s3[PAIR_FS] < sum_s3[PAIR_SF]) ? sum_s3[PAIR_FS] : sum_s3[PAIR_SF];
		min_s3 = (min_b < min_a) ? min_b : min_a;
	end

	// Control state: stage valids and the running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int p = 0; p < NUM_PAIRS; p++) begin
				acc_q[p] <= '0;
			end
		end else begin
			if (s1_free) begin
				v_s1 <= blk.valid;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
			if (s3_free) begin
				v_s3 <= s2_take && last_s2;
			end
			if (out_free) begin
				out_v_q <= v_s3;
			end
			// Accumulate, or drop the sums to zero once a genome ends.
			if (s2_take) begin
				for (int p = 0; p < NUM_PAIRS; p++) begin
					acc_q[p] <= last_s2 ? '0 : sum_next[p];
				end
			end
		end
	end

	// Payload registers: loaded only on a transfer into the stage.
	always_ff @(posedge clk) begin
		if (s1_free && blk.valid) begin
			a1_s1   <= blk.g1_first_word;
			a2_s1   <= blk.g1_second_word;
			b1_s1   <= blk.g2_first_word;
			b2_s1   <= blk.g2_second_word;
			last_s1 <= blk.last_block;
		end
		if (s2_free && v_s1) begin
			cnt_s2[PAIR_FF] <= diff_nucs(a1_s1 ^ b1_s1);
			cnt_s2[PAIR_SS] <= diff_nucs(a2_s1 ^ b2_s1);
			cnt_s2[PAIR_SF] <= diff_nucs(a2_s1 ^ b1_s1);
			cnt_s2[PAIR_FS] <= diff_nucs(a1_s1 ^ b2_s1);
			last_s2         <= last_s1;
		end
		if (s2_take && last_s2) begin
			for (int p = 0; p < NUM_PAIRS; p++) begin
				sum_s3[p] <= sum_next[p];
			end
		end
		if (out_free && v_s3) begin
			min_q <= min_s3;
		end
	end

	assign res.valid        = out_v_q;
	assign res.min_distance = min_q;

	`DND_ASSERT_IMP(a_acc_cap, 1'b1, acc_q[PAIR_FF] <= SUM_MAX && acc_q[PAIR_SS] <= SUM_MAX && acc_q[PAIR_SF] <= SUM_MAX && acc_q[PAIR_FS] <= SUM_MAX)
	`DND_ASSERT_NXT(a_acc_clear, s2_take && last_s2, acc_q[PAIR_FF] == '0 && acc_q[PAIR_SS] == '0 && acc_q[PAIR_SF] == '0 && acc_q[PAIR_FS] == '0)
	`DND_ASSERT_NXT(a_result_load, v_s3 && out_free, out_v_q && min_q == $past(min_s3))
	`DND_ASSERT_NXT(a_final_hold, v_s3 && !out_free, v_s3 && $stable(min_s3))
	`DND_ASSERT_IMP(a_min_cap, out_v_q, min_q <= SUM_MAX)

endmodule
`default_nettype wire
